// ===== hdl/gbnscc_pkg.sv =====
// Shared types, codes and reset constants for the Go-Back-N sender with congestion control.
`timescale 1ns / 1ps

package gbnscc_pkg;

	// Default sizing handed to the top-level parameters
	localparam int WINDOW_MAX_DEF  = 1024;
	localparam int OFFSET_BITS_DEF = 31;

	// Fixed field widths on the ports
	localparam int OFS_PORT_W  = 31;
	localparam int LEN_W       = 12;
	localparam int WIN_PORT_W  = 11;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int TIMER_W     = 32;
	localparam int DUP_W       = 4;
	localparam int RESEND_W    = 8;

	// Protocol constants
	localparam int THRESHOLD_RESET = 16;
	localparam int MIN_THRESHOLD   = 2;
	localparam int RECOVERY_EXTRA  = 3;
	localparam logic [DUP_W-1:0]    DUP_SAT    = '1;
	localparam logic [RESEND_W-1:0] REWIND_SAT = '1;

	// Configuration reset values
	localparam logic                  MODE_RESET      = 1'b1;
	localparam logic [LEN_W-1:0]      PAYLOAD_RESET   = 12'd1023;
	localparam logic [WIN_PORT_W-1:0] FIXED_WIN_RESET = 11'd5;
	localparam logic [WIN_PORT_W-1:0] INIT_THR_RESET  = 11'd16;
	localparam logic [DUP_W-1:0]      DUP_LIM_RESET   = 4'd3;
	localparam logic [RESEND_W-1:0]   RESEND_RESET    = 8'd5;
	localparam logic [TIMER_W-1:0]    TIMEOUT_RESET   = 32'd1000;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_ACK   = 2'd1,
		OP_TICK  = 2'd2,
		OP_POLL  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_SEND     = 3'd1,
		EV_TIMEOUT  = 3'd2,
		EV_RECOVERY = 3'd3,
		EV_COMPLETE = 3'd4,
		EV_ABORT    = 3'd5
	} event_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MODE      = 3'd0,
		CFG_PAYLOAD   = 3'd1,
		CFG_FIXED_WIN = 3'd2,
		CFG_INIT_THR  = 3'd3,
		CFG_DUP_LIM   = 3'd4,
		CFG_RESEND    = 3'd5,
		CFG_TIMEOUT   = 3'd6
	} cfg_index_t;

	typedef struct packed {
		opcode_t                 opcode;
		logic [OFS_PORT_W-1:0]   transfer_size;
		logic [OFS_PORT_W-1:0]   ack_offset;
	} item_t;

	typedef struct packed {
		event_t                  event_code;
		logic [OFS_PORT_W-1:0]   send_offset;
		logic [LEN_W-1:0]        send_length;
		logic                    send_last;
		logic [WIN_PORT_W-1:0]   window_segments;
		logic [WIN_PORT_W-1:0]   slow_start_threshold;
		logic [OFS_PORT_W-1:0]   acked_base;
	} result_t;

	typedef struct packed {
		logic                    congestion_mode;
		logic [LEN_W-1:0]        payload_bytes;
		logic [WIN_PORT_W-1:0]   fixed_window_segments;
		logic [WIN_PORT_W-1:0]   initial_threshold;
		logic [DUP_W-1:0]        dup_ack_limit;
		logic [RESEND_W-1:0]     resend_limit;
		logic [TIMER_W-1:0]      timeout_ticks;
	} cfg_t;

endpackage

// ===== hdl/gbnscc_cfg.sv =====
// Configuration register file for the Go-Back-N sender.
`timescale 1ns / 1ps

module gbnscc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [gbnscc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [gbnscc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output gbnscc_pkg::cfg_t                    cfg
);

	gbnscc_pkg::cfg_t cfg_q;

	// Register writes; unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.congestion_mode       <= gbnscc_pkg::MODE_RESET;
			cfg_q.payload_bytes         <= gbnscc_pkg::PAYLOAD_RESET;
			cfg_q.fixed_window_segments <= gbnscc_pkg::FIXED_WIN_RESET;
			cfg_q.initial_threshold     <= gbnscc_pkg::INIT_THR_RESET;
			cfg_q.dup_ack_limit         <= gbnscc_pkg::DUP_LIM_RESET;
			cfg_q.resend_limit          <= gbnscc_pkg::RESEND_RESET;
			cfg_q.timeout_ticks         <= gbnscc_pkg::TIMEOUT_RESET;
		end else if (cfg_write) begin
			unique case (gbnscc_pkg::cfg_index_t'(cfg_index))
				gbnscc_pkg::CFG_MODE:      cfg_q.congestion_mode       <= cfg_data[0];
				gbnscc_pkg::CFG_PAYLOAD:   cfg_q.payload_bytes         <=
					cfg_data[gbnscc_pkg::LEN_W-1:0];
				gbnscc_pkg::CFG_FIXED_WIN: cfg_q.fixed_window_segments <=
					cfg_data[gbnscc_pkg::WIN_PORT_W-1:0];
				gbnscc_pkg::CFG_INIT_THR:  cfg_q.initial_threshold     <=
					cfg_data[gbnscc_pkg::WIN_PORT_W-1:0];
				gbnscc_pkg::CFG_DUP_LIM:   cfg_q.dup_ack_limit         <=
					cfg_data[gbnscc_pkg::DUP_W-1:0];
				gbnscc_pkg::CFG_RESEND:    cfg_q.resend_limit          <=
					cfg_data[gbnscc_pkg::RESEND_W-1:0];
				gbnscc_pkg::CFG_TIMEOUT:   cfg_q.timeout_ticks         <=
					cfg_data[gbnscc_pkg::TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/gbnscc_core.sv =====
// Transfer state and single-pass next-state logic for one transaction.
`timescale 1ns / 1ps

module gbnscc_core #(
	parameter int WINDOW_MAX  = gbnscc_pkg::WINDOW_MAX_DEF,
	parameter int OFFSET_BITS = gbnscc_pkg::OFFSET_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  gbnscc_pkg::item_t     item,
	input  gbnscc_pkg::cfg_t      cfg,
	output gbnscc_pkg::result_t   result
);

	localparam int OFS_W  = OFFSET_BITS;
	localparam int LEN_W  = gbnscc_pkg::LEN_W;
	localparam int WIN_W  = $clog2(WINDOW_MAX + 1);
	localparam int THR_MAX = (WINDOW_MAX > gbnscc_pkg::THRESHOLD_RESET) ?
		WINDOW_MAX : gbnscc_pkg::THRESHOLD_RESET;
	localparam int THR_W  = $clog2(THR_MAX + 1);
	localparam int PROD_W = WIN_W + LEN_W;
	localparam int CMP_W  = ((OFS_W > PROD_W) ? OFS_W : PROD_W) + 1;
	localparam int DUP_W  = gbnscc_pkg::DUP_W;
	localparam int RS_W   = gbnscc_pkg::RESEND_W;
	localparam int TMR_W  = gbnscc_pkg::TIMER_W;
	localparam logic [31:0] WMAX32  = 32'(WINDOW_MAX);
	localparam logic [31:0] THR_MIN = 32'(gbnscc_pkg::MIN_THRESHOLD);
	localparam logic [31:0] THR_ADD = 32'(gbnscc_pkg::RECOVERY_EXTRA);

	// Transfer state
	logic              active_q, last_sent_q, in_recovery_q, timer_running_q;
	logic              rewind_base_valid_q;
	logic [OFS_W-1:0]  total_size_q, next_offset_q, base_offset_q;
	logic [OFS_W-1:0]  round_end_offset_q, rewind_base_q;
	logic [WIN_W-1:0]  window_q, sent_in_round_q;
	logic [THR_W-1:0]  threshold_q;
	logic [DUP_W-1:0]  dup_count_q;
	logic [RS_W-1:0]   rewind_count_q;
	logic [TMR_W-1:0]  timer_count_q;

	logic              active_d, last_sent_d, in_recovery_d, timer_running_d;
	logic              rewind_base_valid_d;
	logic [OFS_W-1:0]  total_size_d, next_offset_d, base_offset_d;
	logic [OFS_W-1:0]  round_end_offset_d, rewind_base_d;
	logic [WIN_W-1:0]  window_d, sent_in_round_d;
	logic [THR_W-1:0]  threshold_d;
	logic [DUP_W-1:0]  dup_count_d;
	logic [RS_W-1:0]   rewind_count_d;
	logic [TMR_W-1:0]  timer_count_d;

	// Operand preparation
	logic [LEN_W-1:0]  payload_eff;
	logic [OFS_W-1:0]  size_in, ack_in;
	logic              mode;

	assign mode        = cfg.congestion_mode;
	assign payload_eff = (cfg.payload_bytes == '0) ? LEN_W'(1) : cfg.payload_bytes;
	assign size_in     = OFS_W'(item.transfer_size);
	assign ack_in      = OFS_W'(item.ack_offset);

	// Start: initial window and threshold
	logic [WIN_W-1:0]  start_win;
	logic [THR_W-1:0]  start_thr;
	logic [31:0]       fixed32, init32;

	assign fixed32 = 32'(cfg.fixed_window_segments);
	assign init32  = 32'(cfg.initial_threshold);
	always_comb begin
		if (mode) begin
			start_win = WIN_W'(1);
		end else if (fixed32 == '0) begin
			start_win = WIN_W'(1);
		end else if (fixed32 > WMAX32) begin
			start_win = WIN_W'(WMAX32);
		end else begin
			start_win = WIN_W'(fixed32);
		end
		if (init32 < THR_MIN) begin
			start_thr = THR_W'(THR_MIN);
		end else if (init32 > WMAX32) begin
			start_thr = THR_W'(WMAX32);
		end else begin
			start_thr = THR_W'(init32);
		end
	end

	// Send poll: window room check and segment sizing
	logic [OFS_W-1:0]  outstanding, remaining, send_next;
	logic [PROD_W-1:0] win_bytes;
	logic              room_ok, send_ok;
	logic [LEN_W-1:0]  seg_len;
	logic [WIN_W-1:0]  sent_inc;

	assign outstanding = next_offset_q - base_offset_q;
	assign win_bytes   = PROD_W'(window_q) * PROD_W'(payload_eff);
	assign room_ok     = (CMP_W'(outstanding) + CMP_W'(payload_eff)) <= CMP_W'(win_bytes);
	assign send_ok     = !last_sent_q && (next_offset_q < total_size_q) && room_ok;
	assign remaining   = total_size_q - next_offset_q;
	assign seg_len     = (remaining < OFS_W'(payload_eff)) ? LEN_W'(remaining) : payload_eff;
	assign send_next   = next_offset_q + OFS_W'(seg_len);
	assign sent_inc    = sent_in_round_q + WIN_W'(1);

	// ACK: advance, window growth, duplicate counting
	logic              ack_adv, ack_dup, ack_beyond;
	logic [31:0]       grow_dbl, grow_inc, grow_sel;
	logic [WIN_W-1:0]  grow_win;
	logic [DUP_W-1:0]  dup_inc, dup_lim;

	assign ack_adv    = (ack_in > base_offset_q) && (ack_in <= total_size_q);
	assign ack_dup    = (ack_in == base_offset_q);
	assign ack_beyond = (ack_in > next_offset_q);
	assign grow_dbl   = 32'(window_q) << 1;
	assign grow_inc   = 32'(window_q) + 32'd1;
	assign grow_sel   = (grow_dbl < 32'(threshold_q)) ? grow_dbl : grow_inc;
	assign grow_win   = (grow_sel > WMAX32) ? WIN_W'(WMAX32) : WIN_W'(grow_sel);
	assign dup_inc    = (dup_count_q == gbnscc_pkg::DUP_SAT) ? dup_count_q :
		dup_count_q + DUP_W'(1);
	assign dup_lim    = (cfg.dup_ack_limit == '0) ? DUP_W'(1) : cfg.dup_ack_limit;

	// Tick: retransmission timer
	logic [TMR_W-1:0]  timer_inc;
	logic              timeout_hit;

	assign timer_inc   = timer_count_q + TMR_W'(1);
	assign timeout_hit = (timer_inc >= cfg.timeout_ticks);

	// Rewind: halved threshold, recovery window, resend limit tracking
	logic [31:0]       half32, rw_thr32, rw_win32;
	logic [THR_W-1:0]  rw_thr;
	logic [WIN_W-1:0]  rw_win;
	logic              rw_match, rw_abort;
	logic [RS_W-1:0]   rw_cnt_inc;

	assign half32     = 32'(window_q >> 1);
	assign rw_thr32   = (half32 < THR_MIN) ? THR_MIN : half32;
	assign rw_win32   = rw_thr32 + THR_ADD;
	assign rw_thr     = THR_W'(rw_thr32);
	assign rw_win     = (rw_win32 > WMAX32) ? WIN_W'(WMAX32) : WIN_W'(rw_win32);
	assign rw_match   = rewind_base_valid_q && (rewind_base_q == base_offset_q);
	assign rw_cnt_inc = (rewind_count_q == gbnscc_pkg::REWIND_SAT) ? rewind_count_q :
		rewind_count_q + RS_W'(1);
	assign rw_abort   = rw_match && (cfg.resend_limit != '0) &&
		(rw_cnt_inc == cfg.resend_limit);

	// Next state and result for the transaction
	gbnscc_pkg::event_t ev, rw_code;
	logic              do_rewind;
	logic [OFS_W-1:0]  s_off;
	logic [LEN_W-1:0]  s_len;
	logic              s_last;

	always_comb begin
		active_d            = active_q;
		last_sent_d         = last_sent_q;
		in_recovery_d       = in_recovery_q;
		timer_running_d     = timer_running_q;
		rewind_base_valid_d = rewind_base_valid_q;
		total_size_d        = total_size_q;
		next_offset_d       = next_offset_q;
		base_offset_d       = base_offset_q;
		round_end_offset_d  = round_end_offset_q;
		rewind_base_d       = rewind_base_q;
		window_d            = window_q;
		sent_in_round_d     = sent_in_round_q;
		threshold_d         = threshold_q;
		dup_count_d         = dup_count_q;
		rewind_count_d      = rewind_count_q;
		timer_count_d       = timer_count_q;
		ev                  = gbnscc_pkg::EV_NONE;
		rw_code             = gbnscc_pkg::EV_TIMEOUT;
		do_rewind           = 1'b0;
		s_off               = '0;
		s_len               = '0;
		s_last              = 1'b0;

		if (item.opcode == gbnscc_pkg::OP_START) begin
			total_size_d        = size_in;
			next_offset_d       = '0;
			base_offset_d       = '0;
			round_end_offset_d  = '0;
			rewind_base_d       = '0;
			last_sent_d         = 1'b0;
			in_recovery_d       = 1'b0;
			timer_running_d     = 1'b0;
			rewind_base_valid_d = 1'b0;
			sent_in_round_d     = '0;
			dup_count_d         = '0;
			rewind_count_d      = '0;
			timer_count_d       = '0;
			window_d            = start_win;
			threshold_d         = start_thr;
			if (size_in == '0) begin
				active_d = 1'b0;
				ev       = gbnscc_pkg::EV_COMPLETE;
			end else begin
				active_d = 1'b1;
			end
		end else if (active_q) begin
			unique case (item.opcode)
				gbnscc_pkg::OP_POLL: begin
					if (send_ok) begin
						s_off         = next_offset_q;
						s_len         = seg_len;
						s_last        = (send_next >= total_size_q);
						next_offset_d = send_next;
						last_sent_d   = s_last;
						ev            = gbnscc_pkg::EV_SEND;
						if (!timer_running_q) begin
							timer_running_d = 1'b1;
							timer_count_d   = '0;
						end
						if (mode) begin
							if (sent_in_round_q < window_q) begin
								sent_in_round_d = sent_inc;
								if (sent_inc == window_q) begin
									round_end_offset_d = send_next;
								end
							end else begin
								sent_in_round_d = WIN_W'(1);
							end
						end
					end
				end
				gbnscc_pkg::OP_ACK: begin
					if (ack_adv) begin
						base_offset_d = ack_in;
						if (ack_beyond) begin
							next_offset_d = ack_in;
							if (ack_in >= total_size_q) begin
								last_sent_d = 1'b1;
							end
						end
						timer_count_d = '0;
						dup_count_d   = '0;
						in_recovery_d = 1'b0;
						if (mode && !last_sent_d && (ack_in >= round_end_offset_q)) begin
							window_d = grow_win;
						end
						if (ack_in == total_size_q) begin
							active_d        = 1'b0;
							timer_running_d = 1'b0;
							ev              = gbnscc_pkg::EV_COMPLETE;
						end
					end else if (ack_dup && mode && !in_recovery_q) begin
						dup_count_d = dup_inc;
						if (dup_inc == dup_lim) begin
							do_rewind = 1'b1;
							rw_code   = gbnscc_pkg::EV_RECOVERY;
						end
					end
				end
				gbnscc_pkg::OP_TICK: begin
					if (timer_running_q) begin
						timer_count_d = timer_inc;
						if (timeout_hit) begin
							do_rewind = 1'b1;
							rw_code   = gbnscc_pkg::EV_TIMEOUT;
						end
					end
				end
				default: ;
			endcase
		end

		// Go back to the acknowledged base
		if (do_rewind) begin
			next_offset_d   = base_offset_q;
			last_sent_d     = 1'b0;
			timer_running_d = 1'b0;
			timer_count_d   = '0;
			if (mode) begin
				threshold_d        = rw_thr;
				window_d           = rw_win;
				sent_in_round_d    = '0;
				round_end_offset_d = '0;
				dup_count_d        = '0;
				if (rw_code == gbnscc_pkg::EV_RECOVERY) begin
					in_recovery_d = 1'b1;
				end
			end
			if (rw_match) begin
				rewind_count_d = rw_cnt_inc;
				if (rw_abort) begin
					active_d = 1'b0;
					ev       = gbnscc_pkg::EV_ABORT;
				end else begin
					ev = rw_code;
				end
			end else begin
				rewind_base_d       = base_offset_q;
				rewind_base_valid_d = 1'b1;
				rewind_count_d      = '0;
				ev                  = rw_code;
			end
		end
	end

	// Result reflects the state after the transaction
	always_comb begin
		result.event_code           = ev;
		result.send_offset          = gbnscc_pkg::OFS_PORT_W'(s_off);
		result.send_length          = s_len;
		result.send_last            = s_last;
		result.window_segments      = gbnscc_pkg::WIN_PORT_W'(window_d);
		result.slow_start_threshold = gbnscc_pkg::WIN_PORT_W'(threshold_d);
		result.acked_base           = gbnscc_pkg::OFS_PORT_W'(base_offset_d);
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q            <= 1'b0;
			last_sent_q         <= 1'b0;
			in_recovery_q       <= 1'b0;
			timer_running_q     <= 1'b0;
			rewind_base_valid_q <= 1'b0;
			total_size_q        <= '0;
			next_offset_q       <= '0;
			base_offset_q       <= '0;
			round_end_offset_q  <= '0;
			rewind_base_q       <= '0;
			window_q            <= WIN_W'(1);
			sent_in_round_q     <= '0;
			threshold_q         <= THR_W'(gbnscc_pkg::THRESHOLD_RESET);
			dup_count_q         <= '0;
			rewind_count_q      <= '0;
			timer_count_q       <= '0;
		end else if (fire) begin
			active_q            <= active_d;
			last_sent_q         <= last_sent_d;
			in_recovery_q       <= in_recovery_d;
			timer_running_q     <= timer_running_d;
			rewind_base_valid_q <= rewind_base_valid_d;
			total_size_q        <= total_size_d;
			next_offset_q       <= next_offset_d;
			base_offset_q       <= base_offset_d;
			round_end_offset_q  <= round_end_offset_d;
			rewind_base_q       <= rewind_base_d;
			window_q            <= window_d;
			sent_in_round_q     <= sent_in_round_d;
			threshold_q         <= threshold_d;
			dup_count_q         <= dup_count_d;
			rewind_count_q      <= rewind_count_d;
			timer_count_q       <= timer_count_d;
		end
	end

endmodule

// ===== hdl/gbn_sender_congestion_control.sv =====
// Top level: input stage, transfer core and result stage of the Go-Back-N sender.
`timescale 1ns / 1ps
// Path: a transaction accepted into the input register is processed by the core, and its
// result is captured in the result register and presented on the result port.
// Throughput: one transaction per cycle while no result is stalled in the output register.
// While a result is stalled in the output register, the input register takes one more
// transaction and then the input stalls until the result drains.
// Reset (arst_n low, asynchronous): both stages empty, transfer idle, window 1,
// threshold 16, configuration registers at their defaults.

module gbn_sender_congestion_control #(
	parameter int WINDOW_MAX  = gbnscc_pkg::WINDOW_MAX_DEF,
	parameter int OFFSET_BITS = gbnscc_pkg::OFFSET_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [gbnscc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [gbnscc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  gbnscc_pkg::item_t                   item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output gbnscc_pkg::result_t                 result
);

	gbnscc_pkg::cfg_t     cfg;
	gbnscc_pkg::item_t    item_s1;
	logic                 item_valid_s1;
	gbnscc_pkg::result_t  core_result;
	gbnscc_pkg::result_t  result_s2;
	logic                 result_valid_s2;
	logic                 advance, take;

	// Stage 1 moves on whenever the result register is free or being drained
	assign advance    = item_valid_s1 && (!result_valid_s2 || !result_stall);
	assign item_stall = item_valid_s1 && !advance;
	assign take       = item_valid && !item_stall;

	gbnscc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gbnscc_core #(
		.WINDOW_MAX  (WINDOW_MAX),
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_result)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (take) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= core_result;
		end
	end

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

endmodule

// ===== hdl/gbnscc_checker.sv =====
// Port-level checker for the Go-Back-N sender, bound to the top level.
`timescale 1ns / 1ps

module gbnscc_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_stall,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  gbnscc_pkg::result_t  result
);

	// A stalled result transaction holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
	else $error("result changed while stalled");

	// With no result waiting, the input side is never held off
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !item_stall)
	else $error("input stalled with empty result register");

	// Segment fields are zero unless a segment is sent
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.event_code != gbnscc_pkg::EV_SEND) |->
		(result.send_offset == '0) && (result.send_length == '0) && !result.send_last)
	else $error("segment fields set without a send");

	// A sent segment always carries data
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.event_code == gbnscc_pkg::EV_SEND) |->
		(result.send_length != '0))
	else $error("empty segment sent");

endmodule

bind gbn_sender_congestion_control gbnscc_checker u_gbnscc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the Go-Back-N sender with congestion control.
`timescale 1ns / 1ps

module tb;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int          HOLD_CYCLES = 6;
	localparam int          PHASE_ITEMS = 130;

	localparam int OFS_W  = gbnscc_pkg::OFS_PORT_W;
	localparam int LEN_W  = gbnscc_pkg::LEN_W;
	localparam int WIN_W  = gbnscc_pkg::WIN_PORT_W;
	localparam int DUP_W  = gbnscc_pkg::DUP_W;
	localparam int RS_W   = gbnscc_pkg::RESEND_W;
	localparam int TMR_W  = gbnscc_pkg::TIMER_W;
	localparam int IDX_W  = gbnscc_pkg::CFG_INDEX_W;
	localparam int DATA_W = gbnscc_pkg::CFG_DATA_W;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_write    = 1'b0;
	logic [IDX_W-1:0]      cfg_index    = '0;
	logic [DATA_W-1:0]     cfg_data     = '0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	gbnscc_pkg::item_t     item         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	gbnscc_pkg::result_t   result;

	gbn_sender_congestion_control dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// 20 ns clock
	always #10 clk = ~clk;

	gbnscc_pkg::result_t expected_results[$];
	int          mismatches  = 0;
	int unsigned cycle_count = 0;
	bit          quiet       = 1'b0;

	// Shadow copy of the configuration registers
	logic              cur_mode;
	logic [LEN_W-1:0]  cur_payload;
	logic [WIN_W-1:0]  cur_fixed_win;
	logic [WIN_W-1:0]  cur_init_thr;
	logic [DUP_W-1:0]  cur_dup_lim;
	logic [RS_W-1:0]   cur_resend;
	logic [TMR_W-1:0]  cur_timeout;

	// Shadow transfer state
	logic              xfer_active, all_sent, recovering, timer_on, rewind_seen;
	logic [OFS_W-1:0]  xfer_size, send_ptr, base_ptr, round_end, rewind_at;
	logic [WIN_W-1:0]  cwnd, ssthresh, round_sent;
	logic [DUP_W-1:0]  dup_acks;
	logic [RS_W-1:0]   rewinds;
	logic [TMR_W-1:0]  ticks_idle;

	function automatic void reset_shadow();
		cur_mode      = gbnscc_pkg::MODE_RESET;
		cur_payload   = gbnscc_pkg::PAYLOAD_RESET;
		cur_fixed_win = gbnscc_pkg::FIXED_WIN_RESET;
		cur_init_thr  = gbnscc_pkg::INIT_THR_RESET;
		cur_dup_lim   = gbnscc_pkg::DUP_LIM_RESET;
		cur_resend    = gbnscc_pkg::RESEND_RESET;
		cur_timeout   = gbnscc_pkg::TIMEOUT_RESET;
		xfer_active = 1'b0; all_sent = 1'b0; recovering = 1'b0;
		timer_on = 1'b0; rewind_seen = 1'b0;
		xfer_size = '0; send_ptr = '0; base_ptr = '0; round_end = '0; rewind_at = '0;
		cwnd = WIN_W'(1);
		ssthresh = WIN_W'(gbnscc_pkg::THRESHOLD_RESET);
		round_sent = '0; dup_acks = '0; rewinds = '0; ticks_idle = '0;
	endfunction

	function automatic logic [WIN_W-1:0] win_clamp(longint unsigned v, int unsigned lo);
		if (v < 64'(lo))
			return WIN_W'(lo);
		if (v > 64'(gbnscc_pkg::WINDOW_MAX_DEF))
			return WIN_W'(gbnscc_pkg::WINDOW_MAX_DEF);
		return WIN_W'(v);
	endfunction

	// Go back to the acked base; counts repeated rewinds at one base and aborts at the limit
	function automatic gbnscc_pkg::event_t rewind_to_base(gbnscc_pkg::event_t code);
		logic [WIN_W-1:0] half;
		send_ptr   = base_ptr;
		all_sent   = 1'b0;
		timer_on   = 1'b0;
		ticks_idle = '0;
		if (cur_mode) begin
			half = cwnd >> 1;
			if (half < WIN_W'(gbnscc_pkg::MIN_THRESHOLD))
				half = WIN_W'(gbnscc_pkg::MIN_THRESHOLD);
			ssthresh   = half;
			cwnd       = win_clamp(64'(half) + 64'(gbnscc_pkg::RECOVERY_EXTRA), 1);
			round_sent = '0;
			round_end  = '0;
			dup_acks   = '0;
			if (code == gbnscc_pkg::EV_RECOVERY)
				recovering = 1'b1;
		end
		if (rewind_seen && rewind_at == base_ptr) begin
			if (rewinds != gbnscc_pkg::REWIND_SAT)
				rewinds = rewinds + 1'b1;
			if (cur_resend != '0 && rewinds == cur_resend) begin
				xfer_active = 1'b0;
				timer_on    = 1'b0;
				return gbnscc_pkg::EV_ABORT;
			end
		end else begin
			rewind_at   = base_ptr;
			rewind_seen = 1'b1;
			rewinds     = '0;
		end
		return code;
	endfunction

	// Next sender state and the result for one accepted transaction
	function automatic gbnscc_pkg::result_t predict_result(gbnscc_pkg::item_t it);
		gbnscc_pkg::result_t r;
		gbnscc_pkg::event_t  ev;
		longint unsigned     seg, in_flight, left, take, grown, ack;
		logic [DUP_W-1:0]    lim;
		r   = '0;
		ev  = gbnscc_pkg::EV_NONE;
		ack = 64'(it.ack_offset);
		seg = (cur_payload == '0) ? 64'd1 : 64'(cur_payload);
		if (it.opcode == gbnscc_pkg::OP_START) begin
			xfer_size = it.transfer_size;
			send_ptr = '0; base_ptr = '0; round_end = '0; rewind_at = '0;
			all_sent = 1'b0; recovering = 1'b0; timer_on = 1'b0; rewind_seen = 1'b0;
			round_sent = '0; dup_acks = '0; rewinds = '0; ticks_idle = '0;
			cwnd     = cur_mode ? WIN_W'(1) : win_clamp(64'(cur_fixed_win), 1);
			ssthresh = win_clamp(64'(cur_init_thr), gbnscc_pkg::MIN_THRESHOLD);
			if (it.transfer_size == '0) begin
				xfer_active = 1'b0;
				ev = gbnscc_pkg::EV_COMPLETE;
			end else begin
				xfer_active = 1'b1;
			end
		end else if (!xfer_active) begin
			ev = gbnscc_pkg::EV_NONE;
		end else if (it.opcode == gbnscc_pkg::OP_POLL) begin
			in_flight = 64'(send_ptr) - 64'(base_ptr);
			if (!all_sent && send_ptr < xfer_size && in_flight + seg <= 64'(cwnd) * seg) begin
				left = 64'(xfer_size) - 64'(send_ptr);
				take = (left < seg) ? left : seg;
				r.send_offset = send_ptr;
				r.send_length = LEN_W'(take);
				send_ptr      = OFS_W'(64'(send_ptr) + take);
				r.send_last   = (send_ptr >= xfer_size);
				all_sent      = r.send_last;
				ev            = gbnscc_pkg::EV_SEND;
				if (!timer_on) begin
					timer_on   = 1'b1;
					ticks_idle = '0;
				end
				// round bookkeeping for once-per-round window growth
				if (cur_mode) begin
					if (round_sent < cwnd) begin
						round_sent = round_sent + 1'b1;
						if (round_sent == cwnd)
							round_end = send_ptr;
					end else begin
						round_sent = WIN_W'(1);
					end
				end
			end
		end else if (it.opcode == gbnscc_pkg::OP_ACK) begin
			if (ack > 64'(base_ptr) && ack <= 64'(xfer_size)) begin
				base_ptr = it.ack_offset;
				if (it.ack_offset > send_ptr) begin
					send_ptr = it.ack_offset;
					if (send_ptr >= xfer_size)
						all_sent = 1'b1;
				end
				ticks_idle = '0;
				dup_acks   = '0;
				recovering = 1'b0;
				if (cur_mode && !all_sent && base_ptr >= round_end) begin
					grown = 64'(cwnd) * 64'd2;
					cwnd  = win_clamp((grown < 64'(ssthresh)) ? grown : 64'(cwnd) + 64'd1, 1);
				end
				if (base_ptr == xfer_size) begin
					xfer_active = 1'b0;
					timer_on    = 1'b0;
					ev          = gbnscc_pkg::EV_COMPLETE;
				end
			end else if (it.ack_offset == base_ptr && cur_mode && !recovering) begin
				lim = (cur_dup_lim == '0) ? DUP_W'(1) : cur_dup_lim;
				if (dup_acks != gbnscc_pkg::DUP_SAT)
					dup_acks = dup_acks + 1'b1;
				if (dup_acks == lim)
					ev = rewind_to_base(gbnscc_pkg::EV_RECOVERY);
			end
		end else begin
			if (timer_on) begin
				ticks_idle = ticks_idle + 1'b1;
				if (ticks_idle >= cur_timeout)
					ev = rewind_to_base(gbnscc_pkg::EV_TIMEOUT);
			end
		end
		r.event_code           = ev;
		r.window_segments      = cwnd;
		r.slow_start_threshold = ssthresh;
		r.acked_base           = base_ptr;
		return r;
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Result side: random stall, compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		result_stall <= !quiet && ($urandom_range(99) < 23);
	end

	always @(posedge clk) begin : check_results
		gbnscc_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: result %h arrived with nothing pending", $time, result);
			end else begin
				want = expected_results.pop_front();
				check_field("event_code", want.event_code, result.event_code);
				check_field("send_offset", want.send_offset, result.send_offset);
				check_field("send_length", want.send_length, result.send_length);
				check_field("send_last", want.send_last, result.send_last);
				check_field("window_segments", want.window_segments, result.window_segments);
				check_field("slow_start_threshold", want.slow_start_threshold,
					result.slow_start_threshold);
				check_field("acked_base", want.acked_base, result.acked_base);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL gbn_sender_congestion_control");
			$finish;
		end
	end

	// Offer one transaction after a random gap, hold it until accepted, then predict
	task automatic send_item(gbnscc_pkg::item_t it);
		while (!quiet && $urandom_range(99) < 23) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		expected_results.push_back(predict_result(it));
	endtask

	task automatic send_fields(gbnscc_pkg::opcode_t op, logic [OFS_W-1:0] size,
		logic [OFS_W-1:0] ack);
		gbnscc_pkg::item_t it;
		it.opcode        = op;
		it.transfer_size = size;
		it.ack_offset    = ack;
		send_item(it);
	endtask

	// Stop sending until every pending result is back, then let the pipe settle
	task automatic drain_results();
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (HOLD_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(gbnscc_pkg::cfg_index_t idx, logic [DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (idx)
			gbnscc_pkg::CFG_MODE:      cur_mode      = val[0];
			gbnscc_pkg::CFG_PAYLOAD:   cur_payload   = val[LEN_W-1:0];
			gbnscc_pkg::CFG_FIXED_WIN: cur_fixed_win = val[WIN_W-1:0];
			gbnscc_pkg::CFG_INIT_THR:  cur_init_thr  = val[WIN_W-1:0];
			gbnscc_pkg::CFG_DUP_LIM:   cur_dup_lim   = val[DUP_W-1:0];
			gbnscc_pkg::CFG_RESEND:    cur_resend    = val[RS_W-1:0];
			gbnscc_pkg::CFG_TIMEOUT:   cur_timeout   = val[TMR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [DATA_W-1:0] mode, logic [DATA_W-1:0] pay,
		logic [DATA_W-1:0] fixed_win, logic [DATA_W-1:0] init_thr,
		logic [DATA_W-1:0] dup_lim, logic [DATA_W-1:0] resend,
		logic [DATA_W-1:0] timeout);
		drain_results();
		write_reg(gbnscc_pkg::CFG_MODE, mode);
		write_reg(gbnscc_pkg::CFG_PAYLOAD, pay);
		write_reg(gbnscc_pkg::CFG_FIXED_WIN, fixed_win);
		write_reg(gbnscc_pkg::CFG_INIT_THR, init_thr);
		write_reg(gbnscc_pkg::CFG_DUP_LIM, dup_lim);
		write_reg(gbnscc_pkg::CFG_RESEND, resend);
		write_reg(gbnscc_pkg::CFG_TIMEOUT, timeout);
	endtask

	// Mostly protocol-shaped traffic driven off the shadow state, plus some noise
	function automatic gbnscc_pkg::item_t random_item();
		gbnscc_pkg::item_t it;
		int unsigned       pick;
		longint unsigned   seg, span;
		seg              = (cur_payload == '0) ? 64'd1 : 64'(cur_payload);
		it.opcode        = gbnscc_pkg::OP_TICK;
		it.transfer_size = OFS_W'($urandom);
		it.ack_offset    = OFS_W'($urandom);
		pick             = $urandom_range(99);
		if ((!xfer_active && pick < 75) || pick < 3) begin
			it.opcode = gbnscc_pkg::OP_START;
			case ($urandom_range(9))
				0: it.transfer_size = '0;
				1: ;  // keep the full-width random size
				default: it.transfer_size = OFS_W'($urandom_range(32'(64'd12 * seg), 1));
			endcase
		end else if (pick < 45) begin
			it.opcode = gbnscc_pkg::OP_POLL;
		end else if (pick < 70) begin
			it.opcode = gbnscc_pkg::OP_ACK;
			if (send_ptr > base_ptr && $urandom_range(6) != 0) begin
				span          = 64'(send_ptr) - 64'(base_ptr);
				it.ack_offset = OFS_W'(64'(base_ptr) + 64'($urandom_range(32'(span), 1)));
			end else if (xfer_size > send_ptr) begin
				// ack past the send point
				span = 64'(xfer_size) - 64'(send_ptr);
				if ($urandom_range(3) != 0 && span > 64'd4 * seg)
					span = 64'd4 * seg;
				it.ack_offset = OFS_W'(64'(send_ptr) + 64'($urandom_range(32'(span), 1)));
			end
		end else if (pick < 78) begin
			it.opcode     = gbnscc_pkg::OP_ACK;
			it.ack_offset = base_ptr;
		end else if (pick < 92) begin
			it.opcode = gbnscc_pkg::OP_TICK;
		end else begin
			it.opcode = gbnscc_pkg::opcode_t'($urandom_range(3));
			if (it.opcode == gbnscc_pkg::OP_ACK) begin
				if ($urandom_range(1) == 1)
					it.ack_offset = OFS_W'(64'(xfer_size) + 64'($urandom_range(3)) + 64'd1);
				else if (base_ptr != '0)
					it.ack_offset = OFS_W'($urandom_range(32'(base_ptr) - 1));
			end
		end
		return it;
	endfunction

	task automatic run_phase(int count);
		repeat (count) send_item(random_item());
	endtask

	// Idle block ignores everything but start
	task automatic test_idle_block();
		send_fields(gbnscc_pkg::OP_ACK, '1, '1);
		send_fields(gbnscc_pkg::OP_TICK, '0, '0);
		send_fields(gbnscc_pkg::OP_POLL, '1, '0);
	endtask

	// Slow start, window full, stale and out-of-range acks, ack past the send point
	task automatic test_congestion_basics();
		apply_settings(1, 100, 5, 4, 2, 2, 2);
		send_fields(gbnscc_pkg::OP_START, '0, '0);
		send_fields(gbnscc_pkg::OP_START, 31'd350, '0);
		send_fields(gbnscc_pkg::OP_POLL, '0, '0);
		send_fields(gbnscc_pkg::OP_POLL, '0, '0);
		send_fields(gbnscc_pkg::OP_ACK, '0, 31'd100);
		send_fields(gbnscc_pkg::OP_POLL, '0, '0);
		send_fields(gbnscc_pkg::OP_POLL, '0, '0);
		send_fields(gbnscc_pkg::OP_POLL, '0, '0);
		send_fields(gbnscc_pkg::OP_ACK, '0, 31'd50);
		send_fields(gbnscc_pkg::OP_ACK, '0, 31'd400);
		send_fields(gbnscc_pkg::OP_ACK, '0, 31'd320);
		send_fields(gbnscc_pkg::OP_POLL, '0, '0);
		send_fields(gbnscc_pkg::OP_ACK, '0, 31'd350);
	endtask

	// Fast recovery, timeouts at the same base up to abort, restart while active
	task automatic test_rewind_abort();
		send_fields(gbnscc_pkg::OP_START, 31'd1000, '0);
		send_fields(gbnscc_pkg::OP_POLL, '0, '0);
		send_fields(gbnscc_pkg::OP_ACK, '0, '0);
		send_fields(gbnscc_pkg::OP_ACK, '0, '0);
		send_fields(gbnscc_pkg::OP_POLL, '0, '0);
		send_fields(gbnscc_pkg::OP_TICK, '0, '0);
		send_fields(gbnscc_pkg::OP_TICK, '0, '0);
		send_fields(gbnscc_pkg::OP_POLL, '0, '0);
		send_fields(gbnscc_pkg::OP_TICK, '0, '0);
		send_fields(gbnscc_pkg::OP_TICK, '0, '0);
		send_fields(gbnscc_pkg::OP_START, 31'd500, '0);
		send_fields(gbnscc_pkg::OP_POLL, '0, '0);
		send_fields(gbnscc_pkg::OP_START, 31'd7, '0);
		send_fields(gbnscc_pkg::OP_POLL, '0, '0);
	endtask

	// Plain mode with zero and oversized registers, then a mode switch mid-transfer
	task automatic test_plain_mode();
		apply_settings(0, 0, 2047, 0, 0, 0, 0);
		send_fields(gbnscc_pkg::OP_START, 31'd5, '0);
		send_fields(gbnscc_pkg::OP_POLL, '0, '0);
		send_fields(gbnscc_pkg::OP_POLL, '0, '0);
		send_fields(gbnscc_pkg::OP_ACK, '0, '0);
		send_fields(gbnscc_pkg::OP_TICK, '0, '0);
		send_fields(gbnscc_pkg::OP_ACK, '0, 31'd5);
		send_fields(gbnscc_pkg::OP_START, '1, '0);
		send_fields(gbnscc_pkg::OP_POLL, '0, '0);
		drain_results();
		write_reg(gbnscc_pkg::CFG_MODE, 1);
		send_fields(gbnscc_pkg::OP_ACK, '0, 31'd1000);
		send_fields(gbnscc_pkg::OP_ACK, '0, '1);
	endtask

	task automatic test_random_traffic();
		apply_settings(1, 64, 5, 8, 3, 4, 6);
		run_phase(PHASE_ITEMS);
		apply_settings(0, 200, 4, 16, 3, 3, 5);
		run_phase(PHASE_ITEMS);
		apply_settings(1, 4095, 2047, 2047, 15, 255, 32'hFFFF_FFFF);
		run_phase(PHASE_ITEMS);
		apply_settings(1, 1, 1, 2, 1, 1, 1);
		run_phase(PHASE_ITEMS);
		repeat (3) begin
			apply_settings($urandom_range(1), $urandom_range(4095), $urandom_range(2047),
				$urandom_range(2047), $urandom_range(15), $urandom_range(255),
				($urandom_range(3) == 0) ? $urandom : $urandom_range(12));
			run_phase(PHASE_ITEMS);
		end
	endtask

	// Back-to-back traffic with neither side idling
	task automatic test_no_idle();
		apply_settings(1, 37, 8, 32, 3, 6, 9);
		quiet = 1'b1;
		run_phase(150);
		quiet = 1'b0;
	endtask

	initial begin
		reset_shadow();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_idle_block();
		test_congestion_basics();
		test_rewind_abort();
		test_plain_mode();
		test_random_traffic();
		test_no_idle();
		drain_results();
		if (mismatches == 0)
			$display("PASS gbn_sender_congestion_control");
		else
			$display("FAIL gbn_sender_congestion_control");
		$finish;
	end

endmodule
